// File: rtl/core/brhp_pkg.sv
package brhp_pkg;

    localparam int unsigned VAL_W   = 63;
    localparam int unsigned PROD_W  = VAL_W + 4;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [7:0] CHR_B     = 8'h62;
    localparam logic [7:0] CHR_Y     = 8'h79;
    localparam logic [7:0] CHR_T     = 8'h74;
    localparam logic [7:0] CHR_E     = 8'h65;
    localparam logic [7:0] CHR_S     = 8'h73;
    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_DASH  = 8'h2D;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    typedef enum logic [9:0] {
        PH_P0    = 10'b00_0000_0001,
        PH_P1    = 10'b00_0000_0010,
        PH_P2    = 10'b00_0000_0100,
        PH_P3    = 10'b00_0000_1000,
        PH_P4    = 10'b00_0001_0000,
        PH_EQ    = 10'b00_0010_0000,
        PH_FIRST = 10'b00_0100_0000,
        PH_LAST  = 10'b00_1000_0000,
        PH_LEN   = 10'b01_0000_0000,
        PH_STOP  = 10'b10_0000_0000
    } phase_t;

    // acc * 10 + d, saturating at VAL_MAX
    function automatic logic [VAL_W-1:0] push_digit(
        input logic [VAL_W-1:0]   acc,
        input logic [DIGIT_W-1:0] d
    );
        logic [PROD_W-1:0] wide;
        logic [PROD_W-1:0] prod;
        wide = {{(PROD_W-VAL_W){1'b0}}, acc};
        prod = (wide << 3) + (wide << 1) + {{(PROD_W-DIGIT_W){1'b0}}, d};
        if (prod[PROD_W-1:VAL_W] != '0)
            return VAL_MAX;
        return prod[VAL_W-1:0];
    endfunction

endpackage

// File: rtl/core/byte_range_header_parser_top.sv
// Result path: the end-of-line byte is captured in the snapshot register,
// which then moves into the result register that drives result_valid.
// Throughput: one byte per cycle while byte_stall is low; the per-byte multiply-by-ten accumulate
// is a single shared shift-add unit, the range check sits in the result stage.
// Reset: parser returns to the first prefix letter, accumulators and
// file_size clear, both stages empty.
module byte_range_header_parser_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [brhp_pkg::VAL_W-1:0] cfg_data,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                text_byte,
    input  logic                      end_of_line,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [brhp_pkg::VAL_W-1:0] first_byte,
    output logic [brhp_pkg::VAL_W-1:0] last_byte,
    output logic [brhp_pkg::VAL_W-1:0] total_length,
    output logic                      format_error,
    output logic                      range_valid
);
    import brhp_pkg::*;

    logic [VAL_W-1:0] file_size_reg;

    phase_t           phase_reg, phase_next;
    logic [VAL_W-1:0] first_reg, first_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic [VAL_W-1:0] len_reg, len_next;
    logic             bad_reg, bad_next;

    logic             snap_valid_reg;
    logic [VAL_W-1:0] snap_first_reg;
    logic [VAL_W-1:0] snap_last_reg;
    logic [VAL_W-1:0] snap_len_reg;
    logic             snap_bad_reg;

    logic             res_valid_reg;
    logic [VAL_W-1:0] res_first_reg;
    logic [VAL_W-1:0] res_last_reg;
    logic [VAL_W-1:0] res_len_reg;
    logic             res_bad_reg;
    logic             res_ok_reg;

    logic             byte_take;
    logic             res_ready;
    logic             snap_move;
    logic             is_digit;
    logic [DIGIT_W-1:0] digit_val;
    logic [7:0]       digit_raw;
    logic [VAL_W-1:0] sel_acc;
    logic [VAL_W-1:0] pushed;
    logic [7:0]       prefix_letter;
    phase_t           prefix_succ;
    logic             line_bad;
    logic             range_ok;

    assign res_ready  = !res_valid_reg || !result_stall;
    assign snap_move  = snap_valid_reg && res_ready;
    assign byte_stall = snap_valid_reg && !res_ready;
    assign byte_take  = byte_valid && !byte_stall;

    assign is_digit  = (text_byte >= CHR_ZERO) && (text_byte <= CHR_NINE);
    assign digit_raw = text_byte - CHR_ZERO;
    assign digit_val = is_digit ? digit_raw[DIGIT_W-1:0] : '0;

    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST: sel_acc = first_reg;
            PH_LAST:  sel_acc = last_reg;
            default:  sel_acc = len_reg;
        endcase
    end

    assign pushed = push_digit(sel_acc, digit_val);

    always_comb
    begin
        unique case (phase_reg)
            PH_P0:   begin prefix_letter = CHR_B; prefix_succ = PH_P1; end
            PH_P1:   begin prefix_letter = CHR_Y; prefix_succ = PH_P2; end
            PH_P2:   begin prefix_letter = CHR_T; prefix_succ = PH_P3; end
            PH_P3:   begin prefix_letter = CHR_E; prefix_succ = PH_P4; end
            PH_P4:   begin prefix_letter = CHR_S; prefix_succ = PH_EQ; end
            default: begin prefix_letter = CHR_B; prefix_succ = PH_STOP; end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        bad_next   = bad_reg;
        unique case (phase_reg) inside
            PH_P0, PH_P1, PH_P2, PH_P3, PH_P4:
            begin
                if (text_byte == prefix_letter)
                    phase_next = prefix_succ;
                else
                begin
                    bad_next   = 1'b1;
                    phase_next = PH_STOP;
                end
            end
            PH_EQ:
                phase_next = (text_byte == CHR_EQ) ? PH_FIRST : PH_STOP;
            PH_FIRST:
            begin
                if (is_digit)
                    first_next = pushed;
                else
                    phase_next = (text_byte == CHR_DASH) ? PH_LAST : PH_STOP;
            end
            PH_LAST:
            begin
                if (is_digit)
                    last_next = pushed;
                else
                    phase_next = (text_byte == CHR_SLASH) ? PH_LEN : PH_STOP;
            end
            PH_LEN:
            begin
                if (is_digit)
                    len_next = pushed;
                else
                    phase_next = PH_STOP;
            end
            default:
                phase_next = PH_STOP;
        endcase
    end

    // still inside the prefix at end of line counts as a format error
    assign line_bad = bad_next || (phase_next == PH_P0) || (phase_next == PH_P1) ||
                      (phase_next == PH_P2) || (phase_next == PH_P3) ||
                      (phase_next == PH_P4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            phase_reg     <= PH_P0;
            first_reg     <= '0;
            last_reg      <= '0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                file_size_reg <= cfg_data;
            if (byte_take)
            begin
                if (end_of_line)
                begin
                    phase_reg <= PH_P0;
                    first_reg <= '0;
                    last_reg  <= '0;
                    len_reg   <= '0;
                    bad_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    first_reg <= first_next;
                    last_reg  <= last_next;
                    len_reg   <= len_next;
                    bad_reg   <= bad_next;
                end
            end
        end
    end

    // end-of-line snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (byte_take && end_of_line)
            snap_valid_reg <= 1'b1;
        else if (snap_move)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && end_of_line)
        begin
            snap_bad_reg   <= line_bad;
            snap_first_reg <= line_bad ? '0 : first_next;
            snap_last_reg  <= line_bad ? '0 : last_next;
            snap_len_reg   <= line_bad ? '0 : len_next;
        end
    end

    assign range_ok = !snap_bad_reg &&
                      (snap_first_reg != '0) &&
                      ((snap_last_reg == '0) || (snap_last_reg > snap_first_reg)) &&
                      (snap_last_reg < file_size_reg) &&
                      (snap_len_reg <= file_size_reg);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_ready)
            res_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (snap_move)
        begin
            res_first_reg <= snap_first_reg;
            res_last_reg  <= snap_last_reg;
            res_len_reg   <= snap_len_reg;
            res_bad_reg   <= snap_bad_reg;
            res_ok_reg    <= range_ok;
        end
    end

    assign result_valid = res_valid_reg;
    assign first_byte   = res_first_reg;
    assign last_byte    = res_last_reg;
    assign total_length = res_len_reg;
    assign format_error = res_bad_reg;
    assign range_valid  = res_ok_reg;

endmodule
